// ----- rtl/dcsr_pkg.sv -----
// Shared types and constants for the duty-cycle serial sensor receiver.
package dcsr_pkg;

   localparam int unsigned DATA_BITS    = 8;
   localparam int unsigned TICK_W       = 16;
   localparam int unsigned READING_W    = 2 * DATA_BITS;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam int unsigned REQ_TDATA_W  = 8;
   localparam int unsigned RSP_TDATA_W  = 24;

   // Register word addresses, decoded on paddr bit 2 only.
   localparam logic CSR_IDX_SETTLE = 1'b0;
   localparam logic CSR_IDX_SAMPLE = 1'b1;

   localparam logic [TICK_W-1:0] SETTLE_RESET = 16'd120;
   localparam logic [TICK_W-1:0] SAMPLE_RESET = 16'd60;

   // Item kinds carried on tuser.
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_START = 1'b1;

   typedef struct packed {
      logic [TICK_W-1:0] settle_ticks;
      logic [TICK_W-1:0] sample_ticks;
   } cfg_type;

   typedef struct packed {
      logic                 sensor_enable;
      logic                 busy_res;
      logic                 done_res;
      logic                 read_ok;
      logic [READING_W-1:0] reading;
      logic                 new_value;
   } rsp_type;

endpackage

// ----- rtl/dcsr_regs.sv -----
// Configuration register file with an APB-style access port.
module dcsr_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dcsr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dcsr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dcsr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output dcsr_pkg::cfg_type               cfg
);
   import dcsr_pkg::*;

   logic [TICK_W-1:0] settle_ff;
   logic [TICK_W-1:0] settle_in;
   logic [TICK_W-1:0] sample_ff;
   logic [TICK_W-1:0] sample_in;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      settle_in = settle_ff;
      sample_in = sample_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            CSR_IDX_SETTLE: settle_in = csr_pwdata[TICK_W-1:0];
            CSR_IDX_SAMPLE: sample_in = csr_pwdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_RESET;
         sample_ff <= SAMPLE_RESET;
      end else begin
         settle_ff <= settle_in;
         sample_ff <= sample_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_SETTLE: csr_prdata = {{(CSR_DATA_W-TICK_W){1'b0}}, settle_ff};
         CSR_IDX_SAMPLE: csr_prdata = {{(CSR_DATA_W-TICK_W){1'b0}}, sample_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.settle_ticks = settle_ff;
   assign cfg.sample_ticks = sample_ff;

endmodule

// ----- rtl/dcsr_fsm.sv -----
// Receive state machine: decodes one pin sample per item and updates the status.
module dcsr_fsm (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic              kind,
   input  logic              pin,
   input  dcsr_pkg::cfg_type cfg,
   output dcsr_pkg::rsp_type result
);
   import dcsr_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SETTLE,
      PH_START_LOW,
      PH_START_HIGH,
      PH_WAIT_FALL,
      PH_DELAY,
      PH_WAIT_RISE
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [3:0]           bit_idx_ff, bit_idx_in;
   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic                 parity_ff, parity_in;
   logic [DATA_BITS-1:0] first_ff, first_in;
   logic                 second_ff, second_in;
   logic [READING_W-1:0] stored_ff, stored_in;
   logic                 new_ff, new_in;

   always_comb begin
      logic [TICK_W-1:0]    tick_inc;
      logic [DATA_BITS-1:0] sb;
      logic                 par;
      logic                 finish;
      logic                 end_ok;
      logic                 end_err;

      phase_in   = phase_ff;
      tick_in    = tick_ff;
      bit_idx_in = bit_idx_ff;
      shift_in   = shift_ff;
      parity_in  = parity_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      stored_in  = stored_ff;
      new_in     = new_ff;
      tick_inc   = tick_ff + 1'b1;
      sb         = shift_ff;
      par        = parity_ff;
      finish     = 1'b0;
      end_ok     = 1'b0;
      end_err    = 1'b0;

      if (kind == KIND_START) begin
         new_in     = 1'b0;
         phase_in   = PH_SETTLE;
         tick_in    = '0;
         bit_idx_in = '0;
         shift_in   = '0;
         parity_in  = 1'b0;
         first_in   = '0;
         second_in  = 1'b0;
      end else begin
         case (phase_ff)
            PH_SETTLE: begin
               if (tick_ff < cfg.settle_ticks) begin
                  tick_in = tick_inc;
               end else begin
                  // The tick that ends settling is already looked at for the start low.
                  phase_in = pin ? PH_START_LOW : PH_START_HIGH;
               end
            end
            PH_START_LOW: begin
               if (!pin) phase_in = PH_START_HIGH;
            end
            PH_START_HIGH: begin
               if (pin) begin
                  bit_idx_in = '0;
                  shift_in   = '0;
                  parity_in  = 1'b0;
                  phase_in   = PH_WAIT_FALL;
               end
            end
            PH_WAIT_FALL: begin
               if (!pin) begin
                  tick_in  = '0;
                  phase_in = PH_DELAY;
               end
            end
            PH_DELAY: begin
               tick_in = tick_inc;
               if (tick_inc >= cfg.sample_ticks) begin
                  if (pin) begin
                     if (bit_idx_ff < 4'(DATA_BITS)) sb[~bit_idx_ff[2:0]] = 1'b1;
                     par    = ~parity_ff;
                     finish = 1'b1;
                  end else begin
                     phase_in = PH_WAIT_RISE;
                  end
               end
            end
            PH_WAIT_RISE: begin
               if (pin) finish = 1'b1;
            end
            default: phase_in = PH_IDLE;
         endcase

         // End of one bit: the data bits, then the parity bit closes the packet.
         if (finish) begin
            shift_in  = sb;
            parity_in = par;
            if (bit_idx_ff < 4'(DATA_BITS)) begin
               bit_idx_in = bit_idx_ff + 1'b1;
               phase_in   = PH_WAIT_FALL;
            end else if (par) begin
               end_err = 1'b1;
            end else if (!second_ff) begin
               first_in  = sb;
               second_in = 1'b1;
               phase_in  = PH_START_LOW;
            end else begin
               stored_in = {first_ff, sb};
               new_in    = 1'b1;
               end_ok    = 1'b1;
            end
            if (end_ok || end_err) phase_in = PH_IDLE;
         end
      end

      result.sensor_enable = (phase_in != PH_IDLE);
      result.busy_res      = (phase_in != PH_IDLE);
      result.done_res      = end_ok || end_err;
      result.read_ok       = end_ok;
      result.reading       = stored_in;
      result.new_value     = new_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         tick_ff    <= '0;
         bit_idx_ff <= '0;
         shift_ff   <= '0;
         parity_ff  <= 1'b0;
         first_ff   <= '0;
         second_ff  <= 1'b0;
         stored_ff  <= '0;
         new_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         bit_idx_ff <= bit_idx_in;
         shift_ff   <= shift_in;
         parity_ff  <= parity_in;
         first_ff   <= first_in;
         second_ff  <= second_in;
         stored_ff  <= stored_in;
         new_ff     <= new_in;
      end
   end

endmodule

// ----- rtl/duty_cycle_serial_sensor_receiver.sv -----
// Top level of the duty-cycle serial sensor receiver: item registers, decoder and CSRs.
// An accepted item is held in the input register, then its result in the result register,
// where it waits for the consumer. Throughput: one item per cycle while rsp_tready is high,
// since each item reads and writes the receive state in a single update. Reset
// is synchronous and active high: the receiver returns to idle, the stored reading and
// flag clear, both pipeline stages empty, and the settle and sample registers load 120
// and 60 ticks.
module duty_cycle_serial_sensor_receiver (
   input  logic                             clock,
   input  logic                             reset,
   // Request item: tdata[0] = data_pin, rest zero; tuser[0] = kind.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dcsr_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tuser,
   // Response item: tdata[0] = sensor_enable, [1] = busy_res, [2] = done_res,
   // [3] = read_ok, [19:4] = reading, [20] = new_value, [23:21] zero.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dcsr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // Configuration port.
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dcsr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dcsr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dcsr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import dcsr_pkg::*;

   cfg_type cfg;
   rsp_type step_result;

   // Input stage: holds one accepted item until the decoder takes it.
   logic    in_valid_ff, in_valid_in;
   logic    in_kind_ff, in_kind_in;
   logic    in_pin_ff, in_pin_in;

   // Result stage: holds one finished result until the consumer takes it.
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   logic    req_accept;
   logic    advance;

   dcsr_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The decoder steps its state exactly when an item moves into the result stage.
   dcsr_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .kind    (in_kind_ff),
      .pin     (in_pin_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // An item moves on whenever the result stage is empty or being emptied this cycle.
   // A waiting result holds off new items only once the input stage is full as well.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_kind_in  = in_kind_ff;
      in_pin_in   = in_pin_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_kind_in  = req_tuser;
         in_pin_in   = req_tdata[0];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = step_result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_kind_ff <= in_kind_in;
      in_pin_ff  <= in_pin_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.new_value, out_ff.reading, out_ff.read_ok,
                        out_ff.done_res, out_ff.busy_res, out_ff.sensor_enable};

`ifndef SYNTHESIS
   // A finished reception always leaves the receiver idle with the sensor off.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.done_res |-> !out_ff.busy_res && !out_ff.sensor_enable)
      else $error("done reported while still busy");

   // A good read is only ever reported on the item that ends a reception.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.read_ok |-> out_ff.done_res && out_ff.new_value)
      else $error("read_ok without done or new value");

   // A start item yields a busy result with the new-value flag cleared.
   assert property (@(posedge clock) disable iff (reset)
      advance && (in_kind_ff == KIND_START) |=> out_valid_ff && out_ff.busy_res
                                                && !out_ff.new_value)
      else $error("start item did not begin a reception");
`endif

endmodule
